// ----- rtl/uart_rx_oversampled_majority_defines.svh -----
// Assertion helpers for the checker file of this block.
`ifndef UART_RX_OVERSAMPLED_MAJORITY_DEFINES_SVH
`define UART_RX_OVERSAMPLED_MAJORITY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URXOM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define URXOM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/uart_rxom_pkg.sv -----
`default_nettype none

package uart_rxom_pkg;

  // Width of the data shift register and of the delivered byte.
  localparam int REG_BITS = 8;

  // Default number of data bits in one frame.
  localparam int DATA_BITS_DEF = 8;

  // Oversampling ratio and the vote threshold for a one.
  localparam logic [1:0] SAMPLES_PER_BIT = 2'd3;
  localparam logic [1:0] MAJORITY        = 2'd2;

  // Width of the data bit counter.
  localparam int BIT_CNT_W = 4;

  typedef logic [REG_BITS-1:0] rx_byte_t;

  // One result of one line sample.
  typedef struct packed {
    logic     byte_valid;
    rx_byte_t byte_value;
    logic     frame_error;
  } rx_result_t;

endpackage

`default_nettype wire

// ----- rtl/uart_rxom_fsm.sv -----
`default_nettype none

module uart_rxom_fsm
  import uart_rxom_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_rx_enable,
  input  wire logic       step,
  input  wire logic       line_level,
  output rx_result_t      result
);

  localparam int INSERT_POS = ((DATA_BITS > REG_BITS) ? REG_BITS : DATA_BITS) - 1;
  localparam logic [BIT_CNT_W-1:0] DATA_BITS_CNT = BIT_CNT_W'(DATA_BITS);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_DATA    = 2'd2,
    PH_STOP    = 2'd3
  } phase_t;

  phase_t               phase_r,      phase_nxt;
  logic [1:0]           sample_cnt_r, sample_cnt_nxt;
  logic [1:0]           high_cnt_r,   high_cnt_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r,    bit_cnt_nxt;
  rx_byte_t             shift_r,      shift_nxt;
  logic                 rx_enable_r;

  logic [1:0]           sample_inc;
  logic [1:0]           high_inc;
  logic [BIT_CNT_W-1:0] bit_inc;
  rx_byte_t             shifted;

  always_comb begin
    sample_inc = (sample_cnt_r == 2'd3) ? sample_cnt_r : sample_cnt_r + 2'd1;
    if (line_level && (high_cnt_r != 2'd3)) begin
      high_inc = high_cnt_r + 2'd1;
    end else begin
      high_inc = high_cnt_r;
    end
    bit_inc = bit_cnt_r + BIT_CNT_W'(1);
    shifted = shift_r >> 1;
    shifted[INSERT_POS] = (high_inc >= MAJORITY) ? 1'b1 : 1'b0;
  end

  always_comb begin
    phase_nxt      = phase_r;
    sample_cnt_nxt = sample_cnt_r;
    high_cnt_nxt   = high_cnt_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    result         = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (rx_enable_r && !line_level) begin
          phase_nxt = PH_CONFIRM;
        end
      end
      PH_CONFIRM: begin
        if (!line_level) begin
          bit_cnt_nxt    = '0;
          high_cnt_nxt   = '0;
          shift_nxt      = '0;
          sample_cnt_nxt = '0;
          phase_nxt      = PH_DATA;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_DATA: begin
        high_cnt_nxt   = high_inc;
        sample_cnt_nxt = sample_inc;
        if (sample_inc >= SAMPLES_PER_BIT) begin
          sample_cnt_nxt = '0;
          high_cnt_nxt   = '0;
          shift_nxt      = shifted;
          bit_cnt_nxt    = bit_inc;
          if (bit_inc >= DATA_BITS_CNT) begin
            bit_cnt_nxt = '0;
            phase_nxt   = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        high_cnt_nxt   = high_inc;
        sample_cnt_nxt = sample_inc;
        if (sample_inc == 2'd2) begin
          if (high_inc == 2'd0) begin
            result.frame_error = 1'b1;
            phase_nxt          = PH_IDLE;
          end
        end else if (sample_inc >= SAMPLES_PER_BIT) begin
          if (high_inc >= MAJORITY) begin
            result.byte_valid = 1'b1;
            result.byte_value = shift_r;
            phase_nxt         = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      sample_cnt_r <= '0;
      high_cnt_r   <= '0;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      rx_enable_r  <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        rx_enable_r <= cfg_rx_enable;
      end
      if (step) begin
        phase_r      <= phase_nxt;
        sample_cnt_r <= sample_cnt_nxt;
        high_cnt_r   <= high_cnt_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/uart_rx_oversampled_majority.sv -----
// UART receiver, 8N1 by default, working on line samples taken at three times
// the baud rate with a two-of-three vote on every data bit.
// The input channel carries one line sample per transfer (in_line_level).
// Each accepted sample produces exactly one result transfer on the output
// channel: out_byte_valid marks a completed byte with a good stop bit and
// out_byte_value carries it, while out_frame_error marks a stop bit that
// showed no high sample by its second sample. Other results are all zero.
// An accepted sample is registered in the input register, then run through the
// receiver state update, and its result is loaded into the result register.
// The block sustains one sample per cycle while the output is not stalled;
// each sample needs a single state update, in order.
// The cfg_ port writes rx_enable; clearing it stops start-bit detection only.
// It should be written while no sample is in flight.
// Reset (rst_n low, synchronous) returns the receiver to idle, sets rx_enable,
// and empties both the input and the result register.
// When the receiver stalls the output, the result is held unchanged; an empty
// input register still accepts one sample, and in_stall rises once it holds one.

`default_nettype none

module uart_rx_oversampled_majority
  import uart_rxom_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration write port.
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_rx_enable,
  // Sample input channel.
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_line_level,
  // Result channel.
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_byte_valid,
  output rx_byte_t        out_byte_value,
  output logic            out_frame_error
);

  // Input register: one sample waiting for the state update.
  logic in_valid_r;
  logic line_r;

  // Result register.
  logic       out_valid_r;
  rx_result_t result_r;

  rx_result_t result_nxt;
  logic       advance;
  logic       step;

  // The result register can load when it is empty or its content is being
  // taken in this cycle.
  assign advance  = !out_valid_r || !out_stall;
  // A sample moves from the input register into the state update.
  assign step     = in_valid_r && advance;
  // The input register is blocked only when it holds a sample that cannot move.
  assign in_stall = in_valid_r && !advance;

  uart_rxom_fsm #(
    .DATA_BITS (DATA_BITS)
  ) u_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_rx_enable (cfg_rx_enable),
    .step          (step),
    .line_level    (line_r),
    .result        (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      line_r <= in_line_level;
    end
    if (step) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_valid  = result_r.byte_valid;
  assign out_byte_value  = result_r.byte_value;
  assign out_frame_error = result_r.frame_error;

endmodule

`default_nettype wire

// ----- rtl/uart_rxom_chk.sv -----
`default_nettype none

`include "uart_rx_oversampled_majority_defines.svh"

module uart_rxom_chk
  import uart_rxom_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire logic     out_byte_valid,
  input wire rx_byte_t out_byte_value,
  input wire logic     out_frame_error
);

  // A frame either delivers a byte or reports an error, never both at once.
  `URXOM_ASSERT_SAME(a_byte_xor_error, clk, rst_n, out_valid, !(out_byte_valid && out_frame_error), "byte and frame error in one result")

  // The byte field is zero unless a byte is being delivered.
  `URXOM_ASSERT_SAME(a_value_zero, clk, rst_n, out_valid && !out_byte_valid, out_byte_value == '0, "byte value set without a byte")

  // A stalled result stays in place with the same content.
  `URXOM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte_valid) && $stable(out_byte_value) && $stable(out_frame_error), "stalled result changed")

  // The input side is only held back by a result that is waiting.
  `URXOM_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a waiting result")

  // A stalled sample stays offered until it is taken.
  `URXOM_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid, "stalled sample withdrawn")

endmodule

bind uart_rx_oversampled_majority uart_rxom_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte_valid  (out_byte_valid),
  .out_byte_value  (out_byte_value),
  .out_frame_error (out_frame_error)
);

`default_nettype wire
